/* design/nbx_pkg.sv */
// Shared types, constants and mask helpers for the netblock exclusion filter.
// No dependencies; used by nbx_ctrl, nbx_datapath and the top level.
`default_nettype none

package nbx_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Address widths of the two families
    localparam int V6_ADDR_W = 128;
    localparam int V4_ADDR_W = 32;

    // EtherTypes that select a table scan
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;

    // Item operation codes
    typedef enum logic
    {
        OP_WRITE    = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    // One table row held in the prefix memory
    typedef struct packed
    {
        logic                 is_v6;
        logic [7:0]           length;
        logic [V6_ADDR_W-1:0] prefix;
    } entry_t;

    // Controller states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed
    {
        logic capture;
        logic scan_issue;
        logic out_load;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed
    {
        logic in_needs_scan;
        logic scan_last;
        logic out_free;
    } dp_status_t;

    // Leading-bit mask for IPv6; lengths of 128 and above give all ones
    function automatic logic [V6_ADDR_W-1:0] lead_mask_v6(input logic [7:0] len);
        lead_mask_v6 = ~({V6_ADDR_W{1'b1}} >> len);
    endfunction

    // Leading-bit mask for IPv4; lengths of 32 and above give all ones
    function automatic logic [V4_ADDR_W-1:0] lead_mask_v4(input logic [7:0] len);
        lead_mask_v4 = ~({V4_ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

/* design/nbx_ctrl.sv */
// Controller state machine of the netblock exclusion filter.
// Depends on nbx_pkg; drives the datapath commands and the input stall.
`default_nettype none

module nbx_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire nbx_pkg::dp_status_t status,
    output nbx_pkg::ctrl_cmd_t      cmd
);

    nbx_pkg::state_t state_reg;
    nbx_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nbx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        item_stall     = 1'b1;
        unique case (state_reg)
            nbx_pkg::ST_IDLE:
            begin
                // take a word; scan only for IP classify items
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_needs_scan ? nbx_pkg::ST_SCAN : nbx_pkg::ST_DONE;
                end
            end
            nbx_pkg::ST_SCAN:
            begin
                // issue one table read per cycle
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = nbx_pkg::ST_FLUSH;
                end
            end
            nbx_pkg::ST_FLUSH:
            begin
                // let the last read entry reach the match flag
                state_next = nbx_pkg::ST_DONE;
            end
            nbx_pkg::ST_DONE:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nbx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nbx_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg != nbx_pkg::ST_IDLE)
        else $error("capture did not start an item");

    a_scan_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nbx_pkg::ST_SCAN && status.scan_last) |=> state_reg == nbx_pkg::ST_FLUSH)
        else $error("scan did not end after the last entry");

    a_flush_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nbx_pkg::ST_FLUSH |=> state_reg == nbx_pkg::ST_DONE)
        else $error("flush did not reach done");

endmodule

`default_nettype wire

/* design/nbx_datapath.sv */
// Datapath of the netblock exclusion filter: entry table, scan, compare, result register.
// Depends on nbx_pkg; driven by commands from nbx_ctrl.
`default_nettype none

module nbx_datapath
#(
    parameter int TABLE_ENTRIES = nbx_pkg::TABLE_ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nbx_pkg::ctrl_cmd_t cmd,
    output nbx_pkg::dp_status_t     status,
    input  wire logic               op,
    input  wire logic [3:0]         entry_index,
    input  wire logic               entry_valid,
    input  wire logic               entry_is_v6,
    input  wire logic [7:0]         entry_prefix_length,
    input  wire logic [15:0]        ethertype,
    input  wire logic [63:0]        addr_one_hi,
    input  wire logic [63:0]        addr_one_lo,
    input  wire logic [63:0]        addr_two_hi,
    input  wire logic [63:0]        addr_two_lo,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic                    accept
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Table storage: valid bits in flops, rows in memory
    logic [TABLE_ENTRIES-1:0] valid_bits_reg;
    nbx_pkg::entry_t          mem [TABLE_ENTRIES];

    // Captured item
    logic [nbx_pkg::V6_ADDR_W-1:0] addr_one_reg;
    logic [nbx_pkg::V6_ADDR_W-1:0] addr_two_reg;
    logic                          want_v6_reg;

    // Scan pipeline
    logic [IDX_W-1:0] scan_reg;
    logic             rd_en_reg;
    logic             rd_valid_reg;
    nbx_pkg::entry_t  rd_row_reg;
    logic             match_reg;

    // Result register
    logic result_valid_reg;
    logic accept_reg;

    // Decode of the incoming word
    logic             is_write;
    logic             in_range;
    logic [IDX_W-1:0] wr_addr;
    nbx_pkg::entry_t  wr_row;

    // Compare of the read entry
    logic [nbx_pkg::V6_ADDR_W-1:0] mask6;
    logic [nbx_pkg::V4_ADDR_W-1:0] mask4;
    logic                          hit6;
    logic                          hit4;
    logic                          entry_hit;

    assign is_write = (nbx_pkg::op_t'(op) == nbx_pkg::OP_WRITE);
    assign in_range = ({5'b0, entry_index} < 9'(TABLE_ENTRIES));
    assign wr_addr  = IDX_W'(entry_index);

    always_comb
    begin
        wr_row.is_v6  = entry_is_v6;
        wr_row.length = entry_prefix_length;
        wr_row.prefix = {addr_one_hi, addr_one_lo};
    end

    // Status toward the controller
    always_comb
    begin
        status.in_needs_scan = !is_write
                               && (ethertype == nbx_pkg::ETH_IPV4
                                   || ethertype == nbx_pkg::ETH_IPV6);
        status.scan_last     = (scan_reg == IDX_W'(TABLE_ENTRIES - 1));
        status.out_free      = !result_valid_reg || !result_stall;
    end

    // Write the table row and take one row per scan step
    always_ff @(posedge clk)
    begin
        if (cmd.capture && is_write && in_range)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (cmd.scan_issue)
        begin
            rd_row_reg <= mem[scan_reg];
        end
    end

    // Hold the addresses of a classify word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_one_reg <= {addr_one_hi, addr_one_lo};
            addr_two_reg <= {addr_two_hi, addr_two_lo};
        end
    end

    // Masked compare of both addresses against the read row
    always_comb
    begin
        mask6     = nbx_pkg::lead_mask_v6(rd_row_reg.length);
        mask4     = nbx_pkg::lead_mask_v4(rd_row_reg.length);
        hit6      = ((addr_one_reg & mask6) == rd_row_reg.prefix)
                    || ((addr_two_reg & mask6) == rd_row_reg.prefix);
        hit4      = ((addr_one_reg[nbx_pkg::V4_ADDR_W-1:0] & mask4)
                        == rd_row_reg.prefix[nbx_pkg::V4_ADDR_W-1:0])
                    || ((addr_two_reg[nbx_pkg::V4_ADDR_W-1:0] & mask4)
                        == rd_row_reg.prefix[nbx_pkg::V4_ADDR_W-1:0]);
        entry_hit = rd_en_reg && rd_valid_reg && (rd_row_reg.is_v6 == want_v6_reg)
                    && (want_v6_reg ? hit6 : hit4);
    end

    // Control state: valid bits, scan counter, match flag, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg   <= '0;
            want_v6_reg      <= 1'b0;
            scan_reg         <= '0;
            rd_en_reg        <= 1'b0;
            rd_valid_reg     <= 1'b0;
            match_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            accept_reg       <= 1'b1;
        end
        else
        begin
            // start a new word
            if (cmd.capture)
            begin
                want_v6_reg <= (ethertype == nbx_pkg::ETH_IPV6);
                scan_reg    <= '0;
                match_reg   <= 1'b0;
                if (is_write && in_range)
                begin
                    valid_bits_reg[wr_addr] <= entry_valid;
                end
            end
            else
            begin
                // advance the scan
                if (cmd.scan_issue)
                begin
                    scan_reg <= scan_reg + IDX_W'(1);
                end
                if (entry_hit)
                begin
                    match_reg <= 1'b1;
                end
            end
            rd_en_reg <= cmd.scan_issue;
            if (cmd.scan_issue)
            begin
                rd_valid_reg <= valid_bits_reg[scan_reg];
            end
            // load or drain the result
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
                accept_reg       <= !match_reg;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign accept       = accept_reg;

    // Checks
    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result_valid_reg)
        else $error("loaded result not presented");

    a_capture_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (!match_reg && scan_reg == '0))
        else $error("new word did not clear the scan state");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(accept_reg)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

/* design/ip_netblock_exclusion_filter.sv */
// Top level of the netblock exclusion filter: controller plus datapath.
// Depends on nbx_pkg, nbx_ctrl and nbx_datapath.
`default_nettype none

// Filters frames against a table of excluded IPv4 and IPv6 netblocks. A write
// word (op 0) replaces one table slot; a slot index at or beyond the table
// depth is ignored. A classify word (op 1) with EtherType 0x0800 or 0x86dd is
// rejected (accept 0) when its source or destination address, masked to the
// leading bits of a valid entry of the same family, equals that entry's
// prefix; every other word yields accept 1. Write words and classify words of
// other EtherTypes go from idle to done and back to idle. An IPv4 or IPv6
// classify word also passes the scan and flush states: the table memory has
// a single read port and the scan reads one entry per cycle. The next word
// is taken while a finished result still waits in the output register.

module ip_netblock_exclusion_filter
#(
    parameter int TABLE_ENTRIES = nbx_pkg::TABLE_ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        op,
    input  wire logic [3:0]  entry_index,
    input  wire logic        entry_valid,
    input  wire logic        entry_is_v6,
    input  wire logic [7:0]  entry_prefix_length,
    input  wire logic [15:0] ethertype,
    input  wire logic [63:0] addr_one_hi,
    input  wire logic [63:0] addr_one_lo,
    input  wire logic [63:0] addr_two_hi,
    input  wire logic [63:0] addr_two_lo,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             accept
);

    nbx_pkg::ctrl_cmd_t  cmd;
    nbx_pkg::dp_status_t status;

    // Sequence each word
    nbx_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Table, compare and result
    nbx_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .op                  (op),
        .entry_index         (entry_index),
        .entry_valid         (entry_valid),
        .entry_is_v6         (entry_is_v6),
        .entry_prefix_length (entry_prefix_length),
        .ethertype           (ethertype),
        .addr_one_hi         (addr_one_hi),
        .addr_one_lo         (addr_one_lo),
        .addr_two_hi         (addr_two_hi),
        .addr_two_lo         (addr_two_lo),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .accept              (accept)
    );

endmodule

`default_nettype wire
